// ===== hw/rtl/crrt_pkg.sv =====
package crrt_pkg;

	localparam int SOURCES = 8;
	localparam int CHUNKS  = 32;

	localparam int SRC_W   = $clog2(SOURCES);
	localparam int IDX_W   = $clog2(CHUNKS);
	localparam int CNT_W   = 4;
	localparam int TIME_W  = 16;
	localparam int KIND_W  = 2;
	localparam int ADDR_W  = SRC_W + IDX_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_CHUNK = 1'b1;

	localparam logic [KIND_W-1:0] KIND_READY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RETRY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT    = 1'b1;

	localparam logic [TIME_W-1:0] RETRY_INTERVAL_RST = 16'd3;
	localparam logic [CNT_W-1:0]  RETRY_LIMIT_RST    = 4'd5;

	typedef struct packed {
		logic [TIME_W-1:0] interval;
		logic [CNT_W-1:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [CHUNKS-1:0] rmap;
		logic              fvalid;
		logic [IDX_W-1:0]  fidx;
	} slot_ent_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [TIME_W-1:0] stamp;
	} chunk_ent_t;

endpackage

// ===== hw/rtl/crrt_ram.sv =====
module crrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/crrt_ctrl.sv =====
module crrt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  crrt_pkg::cfg_t             cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [crrt_pkg::SRC_W-1:0] source,
	input  logic [crrt_pkg::IDX_W-1:0] chunk_index,
	input  logic                       final_flag,
	input  logic [crrt_pkg::TIME_W-1:0] now,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [crrt_pkg::KIND_W-1:0] kind,
	output logic [crrt_pkg::SRC_W-1:0] source_res,
	output logic [crrt_pkg::IDX_W-1:0] chunk_index_res,
	output logic                       last,
	output logic                       slot_we,
	output logic [crrt_pkg::SRC_W-1:0] slot_waddr,
	output crrt_pkg::slot_ent_t        slot_wdata,
	output logic                       slot_re,
	output logic [crrt_pkg::SRC_W-1:0] slot_raddr,
	input  crrt_pkg::slot_ent_t        slot_rdata,
	output logic                       chunk_we,
	output logic [crrt_pkg::ADDR_W-1:0] chunk_waddr,
	output crrt_pkg::chunk_ent_t       chunk_wdata,
	output logic                       chunk_re,
	output logic [crrt_pkg::ADDR_W-1:0] chunk_raddr,
	input  crrt_pkg::chunk_ent_t       chunk_rdata
);

	import crrt_pkg::*;

	localparam int I_W = IDX_W + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_SLOT  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_EVAL  = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]         state_q, state_d;
	logic [SOURCES-1:0] active_q, active_d;
	logic [SRC_W-1:0]   src_q, src_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               fin_q, fin_d;
	logic [TIME_W-1:0]  now_q, now_d;
	logic [I_W-1:0]     i_q, i_d;
	logic [CHUNKS-1:0]  map_q, map_d;
	logic [IDX_W-1:0]   fidx_q, fidx_d;
	logic               miss_q, miss_d;

	logic               pend_valid_q, pend_valid_d;
	logic [KIND_W-1:0]  pend_kind_q, pend_kind_d;
	logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;

	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [SRC_W-1:0]   out_src_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_last_q;

	logic               out_free;
	logic               in_acc;
	logic               push;
	logic               push_last;
	slot_ent_t          slot_upd;
	logic [TIME_W-1:0]  age;
	logic               due;
	logic [CNT_W-1:0]   cnt_inc;
	logic               over;
	logic               scan_end;
	logic               cur_rcv;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	assign slot_upd.rmap   = slot_rdata.rmap | (CHUNKS'(1) << idx_q);
	assign slot_upd.fvalid = slot_rdata.fvalid | fin_q;
	assign slot_upd.fidx   = fin_q ? idx_q : slot_rdata.fidx;

	assign age      = now_q - chunk_rdata.stamp;
	assign due      = age > cfg.interval;
	assign cnt_inc  = (chunk_rdata.cnt == {CNT_W{1'b1}}) ? chunk_rdata.cnt
	                                                     : chunk_rdata.cnt + CNT_W'(1);
	assign over     = cnt_inc > cfg.retry_limit;
	assign scan_end = i_q > {1'b0, fidx_q};
	assign cur_rcv  = map_q[i_q[IDX_W-1:0]];

	always_comb begin
		state_d      = state_q;
		active_d     = active_q;
		src_d        = src_q;
		idx_d        = idx_q;
		fin_d        = fin_q;
		now_d        = now_q;
		i_d          = i_q;
		map_d        = map_q;
		fidx_d       = fidx_q;
		miss_d       = miss_q;
		pend_valid_d = pend_valid_q;
		pend_kind_d  = pend_kind_q;
		pend_idx_d   = pend_idx_q;
		push         = 1'b0;
		push_last    = 1'b0;
		slot_we      = 1'b0;
		slot_waddr   = src_q;
		slot_wdata   = slot_upd;
		slot_re      = 1'b0;
		slot_raddr   = source;
		chunk_we     = 1'b0;
		chunk_waddr  = {src_q, i_q[IDX_W-1:0]};
		chunk_wdata  = '0;
		chunk_re     = 1'b0;
		chunk_raddr  = {src_q, i_q[IDX_W-1:0]};

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					src_d = source;
					idx_d = chunk_index;
					fin_d = final_flag;
					now_d = now;
					i_d   = '0;
					if (mode == MODE_START) begin
						active_d[source] = 1'b1;
						state_d          = ST_SWEEP;
					end else if (active_q[source]) begin
						slot_re = 1'b1;
						state_d = ST_SLOT;
					end
				end
			end
			ST_SWEEP: begin
				chunk_we   = 1'b1;
				chunk_wdata = '0;
				slot_we    = 1'b1;
				slot_wdata = '0;
				i_d        = i_q + I_W'(1);
				if (i_q[IDX_W-1:0] == IDX_W'(CHUNKS - 1)) begin
					pend_valid_d = 1'b1;
					pend_kind_d  = KIND_READY;
					pend_idx_d   = '0;
					state_d      = ST_FLUSH;
				end
			end
			ST_SLOT: begin
				slot_we = 1'b1;
				map_d   = slot_upd.rmap;
				fidx_d  = slot_upd.fidx;
				miss_d  = 1'b0;
				i_d     = '0;
				state_d = slot_upd.fvalid ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (miss_q) begin
						state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
					end else begin
						active_d[src_q] = 1'b0;
						pend_valid_d    = 1'b1;
						pend_kind_d     = KIND_DONE;
						pend_idx_d      = '0;
						state_d         = ST_FLUSH;
					end
				end else if (cur_rcv) begin
					i_d = i_q + I_W'(1);
				end else begin
					miss_d   = 1'b1;
					chunk_re = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!due) begin
					i_d     = i_q + I_W'(1);
					state_d = ST_SCAN;
				end else if (!pend_valid_q || out_free) begin
					push         = pend_valid_q;
					pend_valid_d = 1'b1;
					pend_idx_d   = i_q[IDX_W-1:0];
					if (over) begin
						active_d[src_q] = 1'b0;
						pend_kind_d     = KIND_ABORT;
						state_d         = ST_FLUSH;
					end else begin
						pend_kind_d       = KIND_RETRY;
						chunk_we          = 1'b1;
						chunk_wdata.cnt   = cnt_inc;
						chunk_wdata.stamp = now_q;
						i_d               = i_q + I_W'(1);
						state_d           = ST_SCAN;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push         = 1'b1;
					push_last    = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			active_q     <= active_d;
			pend_valid_q <= pend_valid_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		src_q       <= src_d;
		idx_q       <= idx_d;
		fin_q       <= fin_d;
		now_q       <= now_d;
		i_q         <= i_d;
		map_q       <= map_d;
		fidx_q      <= fidx_d;
		miss_q      <= miss_d;
		pend_kind_q <= pend_kind_d;
		pend_idx_q  <= pend_idx_d;
		if (push) begin
			out_kind_q <= pend_kind_q;
			out_src_q  <= src_q;
			out_idx_q  <= pend_idx_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_kind_q;
	assign source_res      = out_src_q;
	assign chunk_index_res = out_idx_q;
	assign last            = out_last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left behind at end of item");

	a_rmw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(chunk_we && chunk_re))
		else $error("chunk memory read and written in the same cycle");

	a_eval_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> !scan_end)
		else $error("scan evaluated a chunk past the final index");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_READY || out_kind_q == KIND_DONE
		|| out_kind_q == KIND_ABORT)) |-> out_last_q)
		else $error("terminal result not marked last");

endmodule

// ===== hw/rtl/chunk_reassembly_retry_tracker_top.sv =====
// Receiver-side chunk tracker, one slot per source, with retry, completion and
// abort reporting. A start request sweeps the source's 32 per-chunk entries in
// memory, clearing them and the slot entry, and then gives the ready result. A
// chunk request for an active source reads and writes back its slot entry and,
// once the final index is known, scans chunks 0 to final: a received chunk is
// passed over, a missing chunk has its per-chunk entry read and, if a retry is
// due, written back; an abort ends the scan. Any last result is then handed
// over; a full output register can hold the scan and the hand-over. The scan
// reads one per-chunk entry at a time. A new request is taken once the previous
// one has handed any last result to the output register. Memories need no
// clearing after reset; slot activity flags reset to idle.
module chunk_reassembly_retry_tracker_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [crrt_pkg::SRC_W-1:0]      source,
	input  logic [crrt_pkg::IDX_W-1:0]      chunk_index,
	input  logic                            final_flag,
	input  logic [crrt_pkg::TIME_W-1:0]     now,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [crrt_pkg::KIND_W-1:0]     kind,
	output logic [crrt_pkg::SRC_W-1:0]      source_res,
	output logic [crrt_pkg::IDX_W-1:0]      chunk_index_res,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crrt_pkg::CFG_DATA_W-1:0] cfg_data
);

	import crrt_pkg::*;

	cfg_t       cfg_q;
	logic       slot_we;
	logic [SRC_W-1:0] slot_waddr;
	slot_ent_t  slot_wdata;
	logic       slot_re;
	logic [SRC_W-1:0] slot_raddr;
	slot_ent_t  slot_rdata;
	logic       chunk_we;
	logic [ADDR_W-1:0] chunk_waddr;
	chunk_ent_t chunk_wdata;
	logic       chunk_re;
	logic [ADDR_W-1:0] chunk_raddr;
	chunk_ent_t chunk_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval    <= RETRY_INTERVAL_RST;
			cfg_q.retry_limit <= RETRY_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RETRY_INTERVAL: cfg_q.interval    <= cfg_data[TIME_W-1:0];
				REG_RETRY_LIMIT:    cfg_q.retry_limit <= cfg_data[CNT_W-1:0];
				default:            cfg_q             <= cfg_q;
			endcase
		end
	end

	crrt_ram #(
		.WIDTH ($bits(slot_ent_t)),
		.DEPTH (SOURCES)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	crrt_ram #(
		.WIDTH ($bits(chunk_ent_t)),
		.DEPTH (SOURCES * CHUNKS)
	) u_chunk_ram (
		.clk   (clk),
		.we    (chunk_we),
		.waddr (chunk_waddr),
		.wdata (chunk_wdata),
		.re    (chunk_re),
		.raddr (chunk_raddr),
		.rdata (chunk_rdata)
	);

	crrt_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.source          (source),
		.chunk_index     (chunk_index),
		.final_flag      (final_flag),
		.now             (now),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.source_res      (source_res),
		.chunk_index_res (chunk_index_res),
		.last            (last),
		.slot_we         (slot_we),
		.slot_waddr      (slot_waddr),
		.slot_wdata      (slot_wdata),
		.slot_re         (slot_re),
		.slot_raddr      (slot_raddr),
		.slot_rdata      (slot_rdata),
		.chunk_we        (chunk_we),
		.chunk_waddr     (chunk_waddr),
		.chunk_wdata     (chunk_wdata),
		.chunk_re        (chunk_re),
		.chunk_raddr     (chunk_raddr),
		.chunk_rdata     (chunk_rdata)
	);

endmodule

// ===== tb/sv/tb_chunk_reassembly_retry_tracker_top.sv =====
`timescale 1ns / 100ps

typedef struct packed {
	logic [crrt_pkg::KIND_W-1:0] kind;
	logic [crrt_pkg::SRC_W-1:0]  source;
	logic [crrt_pkg::IDX_W-1:0]  chunk;
	logic                        last;
} tracker_result_t;

class reassembly_scoreboard;
	logic [crrt_pkg::TIME_W-1:0] interval;
	logic [crrt_pkg::CNT_W-1:0]  retry_limit;
	bit                          active [crrt_pkg::SOURCES];
	logic [crrt_pkg::CHUNKS-1:0] rmap   [crrt_pkg::SOURCES];
	logic [crrt_pkg::IDX_W-1:0]  fidx   [crrt_pkg::SOURCES];
	bit                          fvalid [crrt_pkg::SOURCES];
	logic [crrt_pkg::CNT_W-1:0]  cnt    [crrt_pkg::SOURCES][crrt_pkg::CHUNKS];
	logic [crrt_pkg::TIME_W-1:0] stamp  [crrt_pkg::SOURCES][crrt_pkg::CHUNKS];
	tracker_result_t             pending_results[$];
	tracker_result_t             batch[$];
	int                          mismatches;

	function new();
		interval = crrt_pkg::RETRY_INTERVAL_RST;
		retry_limit = crrt_pkg::RETRY_LIMIT_RST;
		mismatches = 0;
		foreach (active[s])
			active[s] = 1'b0;
	endfunction

	function void write_register(logic [crrt_pkg::CFG_IDX_W-1:0] idx,
			logic [crrt_pkg::CFG_DATA_W-1:0] data);
		if (idx == crrt_pkg::REG_RETRY_INTERVAL) begin
			interval = data;
		end else begin
			retry_limit = data[crrt_pkg::CNT_W-1:0];
		end
	endfunction

	function void add_result(logic [crrt_pkg::KIND_W-1:0] k, logic [crrt_pkg::SRC_W-1:0] s,
			logic [crrt_pkg::IDX_W-1:0] c);
		tracker_result_t r;
		r.kind = k;
		r.source = s;
		r.chunk = c;
		r.last = 1'b0;
		batch.push_back(r);
	endfunction

	function void note_request(logic m, logic [crrt_pkg::SRC_W-1:0] src,
			logic [crrt_pkg::IDX_W-1:0] idx, logic fin, logic [crrt_pkg::TIME_W-1:0] now);
		logic [crrt_pkg::TIME_W-1:0] age;
		tracker_result_t r;
		bit aborted;
		bit all_in;
		int i;
		batch.delete();
		if (m == crrt_pkg::MODE_START) begin
			active[src] = 1'b1;
			rmap[src] = '0;
			fidx[src] = '0;
			fvalid[src] = 1'b0;
			for (i = 0; i < crrt_pkg::CHUNKS; i++) begin
				cnt[src][i] = '0;
				stamp[src][i] = '0;
			end
			add_result(crrt_pkg::KIND_READY, src, '0);
		end else begin
			if (!active[src])
				return;
			rmap[src][idx] = 1'b1;
			if (fin) begin
				fidx[src] = idx;
				fvalid[src] = 1'b1;
			end
			if (fvalid[src]) begin
				aborted = 1'b0;
				all_in = 1'b1;
				for (i = 0; i <= fidx[src] && !aborted; i++) begin
					if (!rmap[src][i]) begin
						all_in = 1'b0;
						age = now - stamp[src][i];
						if (age > interval) begin
							if (cnt[src][i] != 4'hf)
								cnt[src][i] = cnt[src][i] + 1'b1;
							if (cnt[src][i] > retry_limit) begin
								active[src] = 1'b0;
								add_result(crrt_pkg::KIND_ABORT, src, i[crrt_pkg::IDX_W-1:0]);
								aborted = 1'b1;
							end else begin
								add_result(crrt_pkg::KIND_RETRY, src, i[crrt_pkg::IDX_W-1:0]);
								stamp[src][i] = now;
							end
						end
					end
				end
				if (!aborted && all_in) begin
					active[src] = 1'b0;
					add_result(crrt_pkg::KIND_DONE, src, '0);
				end
			end
		end
		if (batch.size() > 0) begin
			r = batch.pop_back();
			r.last = 1'b1;
			batch.push_back(r);
		end
		foreach (batch[j])
			pending_results.push_back(batch[j]);
	endfunction

	function void check_result(logic [crrt_pkg::KIND_W-1:0] k, logic [crrt_pkg::SRC_W-1:0] s,
			logic [crrt_pkg::IDX_W-1:0] c, logic l);
		tracker_result_t e;
		if (pending_results.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: kind %0d source %0d chunk %0d last %0d",
					k, s, c, l);
			mismatches++;
			return;
		end
		e = pending_results.pop_front();
		if (k !== e.kind || s !== e.source || c !== e.chunk || l !== e.last) begin
			if (mismatches < 10)
				$display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d (kind src chunk last)",
					e.kind, e.source, e.chunk, e.last, k, s, c, l);
			mismatches++;
		end
	endfunction
endclass

module tb_chunk_reassembly_retry_tracker_top;
	import crrt_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 150;
	localparam int PHASE_REQUESTS = 13;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  mode;
	logic [SRC_W-1:0]      source;
	logic [IDX_W-1:0]      chunk_index;
	logic                  final_flag;
	logic [TIME_W-1:0]     now;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [KIND_W-1:0]     kind;
	logic [SRC_W-1:0]      source_res;
	logic [IDX_W-1:0]      chunk_index_res;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	reassembly_scoreboard sb;
	bit                   calm;
	int                   requests_sent;
	int                   cycles;
	logic [TIME_W-1:0]    tick;

	chunk_reassembly_retry_tracker_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.source(source),
		.chunk_index(chunk_index),
		.final_flag(final_flag),
		.now(now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.source_res(source_res),
		.chunk_index_res(chunk_index_res),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(kind, source_res, chunk_index_res, last);
		out_ready <= calm || ($urandom_range(0, 99) >= 17);
	end

	task automatic send_request(input logic m, input logic [SRC_W-1:0] s,
			input logic [IDX_W-1:0] c, input logic f, input logic [TIME_W-1:0] t);
		if (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		source <= s;
		chunk_index <= c;
		final_flag <= f;
		now <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(m, s, c, f, t);
		requests_sent++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.write_register(idx, data);
	endtask

	// Chunk requests may produce nothing, so allow the scan to finish after the queue drains.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic advance_tick();
		if ($urandom_range(0, 15) == 0)
			tick = tick + 16'($urandom_range(0, 65535));
		else
			tick = tick + 16'($urandom_range(0, 6));
	endtask

	task automatic run_transfer(input int budget);
		logic [SRC_W-1:0] s;
		logic [IDX_W-1:0] c;
		logic             f;
		int               fin_at;
		int               n;
		fin_at = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 31) : $urandom_range(0, 6);
		s = SRC_W'($urandom_range(0, SOURCES - 1));
		advance_tick();
		send_request(MODE_START, s, IDX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
			tick);
		n = $urandom_range(2, fin_at + 4);
		if (n > budget)
			n = budget;
		for (int j = 0; j < n; j++) begin
			advance_tick();
			if ($urandom_range(0, 9) == 0) begin
				send_request(1'($urandom_range(0, 1)), SRC_W'($urandom_range(0, SOURCES - 1)),
					IDX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), tick);
			end else begin
				c = IDX_W'($urandom_range(0, fin_at));
				if ($urandom_range(0, 9) == 0)
					c = IDX_W'($urandom_range(0, 31));
				if (c == fin_at)
					f = ($urandom_range(0, 3) != 0);
				else
					f = ($urandom_range(0, 19) == 0);
				send_request(MODE_CHUNK, s, c, f, tick);
			end
		end
	endtask

	initial begin
		logic [TIME_W-1:0] intervals [6];
		logic [CNT_W-1:0]  limits [6];
		int                target;
		sb = new();
		calm = 1'b0;
		requests_sent = 0;
		tick = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_START;
		source = '0;
		chunk_index = '0;
		final_flag = 1'b0;
		now = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RETRY_INTERVAL;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: open, idle slot, one-chunk transfer, wraparound, restart, abort
		send_request(MODE_START, 3'd0, 5'd0, 1'b0, 16'd0);
		send_request(MODE_CHUNK, 3'd1, 5'd4, 1'b1, 16'd1);
		send_request(MODE_CHUNK, 3'd0, 5'd0, 1'b1, 16'hffff);
		send_request(MODE_CHUNK, 3'd0, 5'd0, 1'b1, 16'd5);
		send_request(MODE_START, 3'd7, 5'd31, 1'b1, 16'hffff);
		send_request(MODE_CHUNK, 3'd7, 5'd31, 1'b0, 16'd0);
		send_request(MODE_CHUNK, 3'd7, 5'd3, 1'b1, 16'd200);
		send_request(MODE_CHUNK, 3'd7, 5'd5, 1'b1, 16'd202);
		send_request(MODE_CHUNK, 3'd7, 5'd1, 1'b0, 16'd0);
		send_request(MODE_START, 3'd7, 5'd0, 1'b0, 16'd300);
		send_request(MODE_CHUNK, 3'd7, 5'd2, 1'b1, 16'd301);
		send_request(MODE_CHUNK, 3'd7, 5'd0, 1'b0, 16'd302);
		send_request(MODE_CHUNK, 3'd7, 5'd1, 1'b0, 16'd303);
		send_request(MODE_START, 3'd2, 5'd0, 1'b0, 16'd1000);
		for (int k = 1; k <= 7; k++)
			send_request(MODE_CHUNK, 3'd2, 5'd1, 1'b1, 16'(1000 + 10 * k));
		send_request(MODE_START, 3'd5, 5'd21, 1'b0, 16'h8000);
		send_request(MODE_CHUNK, 3'd5, 5'd31, 1'b1, 16'h7fff);

		intervals[0] = 16'd0;      limits[0] = 4'd0;
		intervals[1] = 16'hffff;   limits[1] = 4'd15;
		intervals[2] = 16'd1;      limits[2] = 4'd14;
		intervals[3] = 16'($urandom_range(0, 40));
		limits[3] = 4'($urandom_range(1, 14));
		intervals[4] = 16'd0;      limits[4] = 4'd15;
		intervals[5] = 16'd4;      limits[5] = 4'd2;

		for (int p = 0; p < 6; p++) begin
			settle();
			write_register(REG_RETRY_INTERVAL, intervals[p]);
			write_register(REG_RETRY_LIMIT, CFG_DATA_W'(limits[p]));
			calm = (p == 2);
			tick = 16'($urandom_range(0, 65535));
			target = requests_sent + PHASE_REQUESTS;
			while (requests_sent < target)
				run_transfer(target - requests_sent + 1);
		end
		calm = 1'b0;

		settle();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
